FILE: hdl/vtx_pkg.sv
// vtx_pkg: word types and command codes for the 4x4 vertex transform
// no dependencies; imported by every module of the block

package vtx_pkg;

    // command codes of an input word
    localparam logic CmdWrite = 1'b0;
    localparam logic CmdXform = 1'b1;

    // exact row sum: four 64-bit products need 66 bits
    localparam int AccW = 66;

    typedef logic signed [AccW-1:0] t_acc;

    typedef struct packed {
        logic               command;
        logic        [3:0]  element_index;
        logic signed [31:0] element_value;
        logic signed [31:0] vec_x;
        logic signed [31:0] vec_y;
        logic signed [31:0] vec_z;
        logic signed [31:0] vec_w;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] res_x;
        logic signed [31:0] res_y;
        logic signed [31:0] res_z;
        logic signed [31:0] res_w;
    } t_out_word;

    // word plus running row sums, handed from cell to cell
    typedef struct packed {
        t_in_word   word;
        t_acc [3:0] sum;
    } t_link;

endpackage

FILE: hdl/vertex_transform_4x4.sv
// vertex_transform_4x4: 4x4 fixed-point matrix times homogeneous vector
// depends on vtx_pkg and vtx_cell
//
//   channel   direction  handshake                      payload
//   input     in         i_in_valid / o_in_ready        i_word  (t_in_word)
//   output    out        o_out_valid / i_out_ready      o_word  (t_out_word)
//   config    in         i_cfg_wr_en                    i_cfg_wr_data
//
// one word accepted per cycle while o_in_ready is high; a transform result passes
// through nine register stages in all before it is valid at the output: two
// per column cell (multiply, then add) and one output stage for the shift,
// saturation and optional truncation
// synchronous active-low reset restores the identity matrix and clears
// the rounding flag r_round; stall on the output fills pipeline bubbles first, then
// ready drops back along the chain

module vertex_transform_4x4 #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  vtx_pkg::t_in_word  i_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output vtx_pkg::t_out_word o_word,
    input  logic               i_cfg_wr_en,
    input  logic               i_cfg_wr_data
);
    import vtx_pkg::*;

    localparam logic [31:0] FracMask = (32'd1 << FRAC_BITS) - 32'd1;
    localparam logic [31:0] OneWhole = 32'd1 << FRAC_BITS;

    // link[c] feeds cell c; link[4] leaves the last cell
    t_link link  [5];
    logic  lvalid[5];
    logic  lready[5];

    logic      r_round;
    logic      r_out_valid;
    t_out_word r_out_word;
    logic      ld_out;
    logic [31:0] fin [4];

    assign link[0].word = i_word;
    assign link[0].sum  = '0;
    assign lvalid[0]    = i_in_valid;
    assign o_in_ready   = lready[0];

    // chain of column cells, cell c holds column c of the matrix
    for (genvar c = 0; c < 4; c++) begin : g_cell
        vtx_cell #(
            .COL       (c),
            .FRAC_BITS (FRAC_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (lvalid[c]),
            .o_ready (lready[c]),
            .i_link  (link[c]),
            .o_valid (lvalid[c+1]),
            .i_ready (lready[c+1]),
            .o_link  (link[c+1])
        );
    end

    // output stage; write words are dropped here
    assign ld_out    = !r_out_valid || i_out_ready;
    assign lready[4] = ld_out;

    // floor shift, saturate to 32 bits, then truncate toward zero if asked
    always_comb begin
        t_acc        shifted;
        logic [31:0] sat;
        for (int r = 0; r < 4; r++) begin
            shifted = $signed(link[4].sum[r]) >>> FRAC_BITS;
            if ((&shifted[AccW-1:31]) || !(|shifted[AccW-1:31])) begin
                sat = shifted[31:0];
            end else if (shifted[AccW-1]) begin
                sat = 32'h8000_0000;
            end else begin
                sat = 32'h7FFF_FFFF;
            end
            if (r_round) begin
                // negative with a fraction: floor plus one whole step
                if (sat[31] && (|(sat & FracMask))) begin
                    fin[r] = (sat & ~FracMask) + OneWhole;
                end else begin
                    fin[r] = sat & ~FracMask;
                end
            end else begin
                fin[r] = sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_round     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) r_round <= i_cfg_wr_data;
            if (ld_out) r_out_valid <= lvalid[4] && (link[4].word.command == CmdXform);
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_out) begin
            r_out_word.res_x <= fin[0];
            r_out_word.res_y <= fin[1];
            r_out_word.res_z <= fin[2];
            r_out_word.res_w <= fin[3];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_word      = r_out_word;

endmodule

FILE: hdl/vtx_cell.sv
// vtx_cell: one matrix column, its four multipliers and the row sum adders
// depends on vtx_pkg

module vtx_cell #(
    parameter int COL       = 0,
    parameter int FRAC_BITS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  vtx_pkg::t_link i_link,
    output logic           o_valid,
    input  logic           i_ready,
    output vtx_pkg::t_link o_link
);
    import vtx_pkg::*;

    localparam logic signed [31:0] One = 32'sd1 <<< FRAC_BITS;

    logic signed [31:0] r_col [4];

    logic               r_v1;
    t_in_word           r_word1;
    t_acc [3:0]         r_sum1;
    logic signed [63:0] r_prod [4];

    logic               r_v2;
    t_link              r_link2;

    logic               ld1;
    logic               ld2;
    logic signed [31:0] vc;
    logic               wr_hit;

    assign ld2     = !r_v2 || i_ready;
    assign ld1     = !r_v1 || ld2;
    assign o_ready = ld1;
    assign o_valid = r_v2;
    assign o_link  = r_link2;

    always_comb begin
        case (COL)
            0:       vc = i_link.word.vec_x;
            1:       vc = i_link.word.vec_y;
            2:       vc = i_link.word.vec_z;
            default: vc = i_link.word.vec_w;
        endcase
    end

    // a write updates this column as it passes, keeping order with transforms
    assign wr_hit = ld1 && i_valid && (i_link.word.command == CmdWrite)
                    && (i_link.word.element_index[3:2] == 2'(COL));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            for (int r = 0; r < 4; r++) begin
                r_col[r] <= (r == COL) ? One : 32'sd0;
            end
        end else begin
            if (ld1) r_v1 <= i_valid;
            if (ld2) r_v2 <= r_v1;
            if (wr_hit) begin
                r_col[i_link.word.element_index[1:0]] <= i_link.word.element_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld1) begin
            r_word1 <= i_link.word;
            r_sum1  <= i_link.sum;
            for (int r = 0; r < 4; r++) begin
                r_prod[r] <= r_col[r] * vc;
            end
        end
        if (ld2) begin
            r_link2.word <= r_word1;
            for (int r = 0; r < 4; r++) begin
                r_link2.sum[r] <= $signed(r_sum1[r]) + {{(AccW-64){r_prod[r][63]}}, r_prod[r]};
            end
        end
    end

endmodule

FILE: hdl/vtx_checker.sv
// vtx_checker: port-level assertions for vertex_transform_4x4
// depends on vtx_pkg; bound to the top level at the end of this file

module vtx_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input vtx_pkg::t_in_word  i_word,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input vtx_pkg::t_out_word o_word
);
    import vtx_pkg::*;

    // a result word holds while the sink stalls
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_word))
        else $error("result word changed while stalled");

    // reset leaves no result pending
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // with the output register empty the whole chain can move
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output");

    // an input word waiting for ready stays offered and unchanged
    a_in_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_word))
        else $error("input word withdrawn or changed while waiting");

endmodule

bind vertex_transform_4x4 vtx_checker u_vtx_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_word      (i_word),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_word      (o_word)
);

FILE: test/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for vertex_transform_4x4, random and directed words
// depends on vtx_pkg and the vertex_transform_4x4 rtl; scoreboard class kept in this file

module tb;
    import vtx_pkg::*;

    localparam int FracBits = 16;
    // worst quiet stretch is a forced receiver hold plus the longest sender gap plus the
    // pass through the pipe; the limit takes that several times over
    localparam int IdleLimit = 2000;
    // pipe is 9 deep; pad past it before touching the config register
    localparam int DrainPad = 12;
    localparam int PhaseWords = 360;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_word  i_word;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_word o_word;
    logic      i_cfg_wr_en;
    logic      i_cfg_wr_data;

    int squeeze_req;
    int burst_left;

    vertex_transform_4x4 #(
        .FRAC_BITS(FracBits)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_word       (i_word),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_word       (o_word),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data)
    );

    // holds its own copy of the matrix and the rounding flag, works out each
    // transform at acceptance and keeps the results in arrival order
    class xform_scoreboard;
        logic signed [31:0] matrix[16];
        bit                 round_whole;
        t_out_word          pending_results[$];
        int                 n_errors;

        function new();
            for (int i = 0; i < 16; i++) begin
                matrix[i] = (i % 5 == 0) ? 32'(1 << FracBits) : 32'sd0;
            end
            round_whole = 1'b0;
            n_errors = 0;
        endfunction

        function void set_rounding(bit value);
            round_whole = value;
        endfunction

        function int pending_count();
            return pending_results.size();
        endfunction

        // exact 66-bit row sum, floor shift, saturate, then optional truncation
        function logic signed [31:0] transform_row(int row, t_in_word w);
            logic signed [65:0] acc;
            logic signed [65:0] elem;
            logic signed [65:0] comp;
            logic signed [65:0] frac_mask;
            logic signed [31:0] vec[4];
            vec[0] = w.vec_x;
            vec[1] = w.vec_y;
            vec[2] = w.vec_z;
            vec[3] = w.vec_w;
            acc = '0;
            for (int c = 0; c < 4; c++) begin
                elem = matrix[c * 4 + row];
                comp = vec[c];
                acc = acc + elem * comp;
            end
            acc = acc >>> FracBits;
            if (acc > 66'sd2147483647) begin
                acc = 66'sd2147483647;
            end
            if (acc < -66'sd2147483648) begin
                acc = -66'sd2147483648;
            end
            if (round_whole) begin
                frac_mask = (66'sd1 <<< FracBits) - 66'sd1;
                if (acc >= 0) begin
                    acc = acc & ~frac_mask;
                end else begin
                    acc = -((-acc) & ~frac_mask);
                end
            end
            return acc[31:0];
        endfunction

        function void note_input(t_in_word w);
            t_out_word r;
            if (w.command == CmdWrite) begin
                matrix[w.element_index] = w.element_value;
            end else begin
                r.res_x = transform_row(0, w);
                r.res_y = transform_row(1, w);
                r.res_z = transform_row(2, w);
                r.res_w = transform_row(3, w);
                pending_results.push_back(r);
            end
        endfunction

        task report(string msg);
            $display("%0t: mismatch: %s", $time, msg);
            n_errors++;
        endtask

        task check_result(t_out_word got);
            t_out_word   want;
            logic [31:0] got_f[4];
            logic [31:0] want_f[4];
            string       names[4];
            if (pending_results.size() == 0) begin
                report($sformatf("result %h with nothing expected", got));
                return;
            end
            want = pending_results.pop_front();
            names = '{"res_x", "res_y", "res_z", "res_w"};
            got_f = '{got.res_x, got.res_y, got.res_z, got.res_w};
            want_f = '{want.res_x, want.res_y, want.res_z, want.res_w};
            for (int i = 0; i < 4; i++) begin
                if (got_f[i] !== want_f[i]) begin
                    report($sformatf("%s got %h expected %h", names[i], got_f[i], want_f[i]));
                end
            end
        endtask
    endclass

    xform_scoreboard sb = new();

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // monitor: handshake values read right after the edge are the pre-edge ones
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                sb.note_input(i_word);
            end
            if (o_out_valid && i_out_ready) begin
                sb.check_result(o_word);
            end
        end
    end

    // watchdog: ends the run after too many cycles with no word moving either way
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
            if (quiet >= IdleLimit) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // receiver: short stalls, rare long holds, calm stretches with ready held high,
    // and a forced long hold whenever the stimulus asks for one
    initial begin
        int hold_left;
        int calm_left;
        int served;
        int r;
        bit rdy;
        hold_left = 0;
        calm_left = 0;
        served = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else if (served != squeeze_req) begin
                // long hold while the sender keeps going, so the pipe fills and
                // input ready drops
                served = squeeze_req;
                hold_left = 119;
                rdy = 1'b0;
            end else if (calm_left > 0) begin
                calm_left--;
                rdy = 1'b1;
            end else begin
                r = $urandom_range(0, 999);
                rdy = 1'b1;
                if (r < 5) begin
                    hold_left = $urandom_range(20, 60);
                    rdy = 1'b0;
                end else if (r < 40) begin
                    calm_left = $urandom_range(30, 100);
                end else if (r < 250) begin
                    hold_left = $urandom_range(0, 2);
                    rdy = 1'b0;
                end
            end
            i_out_ready <= rdy;
        end
    end

    // sender gap: mostly none or short, a few long, sometimes a burst with none
    function automatic int pick_gap();
        int r;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            return $urandom_range(10, 40);
        end
        if (r < 8) begin
            burst_left = $urandom_range(20, 80);
            return 0;
        end
        if (r < 40) begin
            return $urandom_range(1, 3);
        end
        return 0;
    endfunction

    // offers one word and returns in the step of its acceptance, valid still high
    task automatic send_word(input t_in_word w);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_word <= w;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // sender pauses until every result is back, then lets the pipe run empty
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_count() != 0) @(posedge i_clk);
        repeat (DrainPad) @(posedge i_clk);
    endtask

    task automatic set_round(input bit value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        sb.set_rounding(value);
    endtask

    // matrix write; the vector fields carry noise the block must ignore
    function automatic t_in_word make_write(input logic [3:0] idx, input logic [31:0] val);
        t_in_word w;
        w.command = CmdWrite;
        w.element_index = idx;
        w.element_value = val;
        w.vec_x = $urandom;
        w.vec_y = $urandom;
        w.vec_z = $urandom;
        w.vec_w = $urandom;
        return w;
    endfunction

    // transform; element fields carry noise the block must ignore
    function automatic t_in_word make_xform(input logic [31:0] x, input logic [31:0] y,
                                            input logic [31:0] z, input logic [31:0] wv);
        t_in_word w;
        w.command = CmdXform;
        w.element_index = 4'($urandom);
        w.element_value = $urandom;
        w.vec_x = x;
        w.vec_y = y;
        w.vec_z = z;
        w.vec_w = wv;
        return w;
    endfunction

    // mix of small fractional values, whole values, full-range and corner values
    function automatic logic [31:0] rand_value();
        logic [31:0] corners[7];
        corners = '{32'h7fffffff, 32'h80000000, 32'h0, 32'h1, 32'hffffffff,
                    32'h00010000, 32'hffff0000};
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                return int'($urandom_range(0, 8 << 16)) - (4 << 16);
            end
            4, 5: begin
                return $urandom;
            end
            6: begin
                return corners[$urandom_range(0, 6)];
            end
            7: begin
                return int'($urandom_range(0, 512 << 16)) - (256 << 16);
            end
            default: begin
                return (int'($urandom_range(0, 16)) - 8) <<< 16;
            end
        endcase
    endfunction

    function automatic t_in_word random_word();
        logic [31:0] zv;
        logic [31:0] wv;
        if ($urandom_range(0, 4) == 0) begin
            return make_write(4'($urandom), rand_value());
        end
        // plain points use w of one and 2D points a zero z
        zv = ($urandom_range(0, 4) == 0) ? 32'h0 : rand_value();
        wv = ($urandom_range(0, 1) == 0) ? 32'h00010000 : rand_value();
        return make_xform(rand_value(), rand_value(), zv, wv);
    endfunction

    initial begin
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_word <= '0;
        i_cfg_wr_en <= 1'b0;
        i_cfg_wr_data <= 1'b0;
        squeeze_req = 0;
        burst_left = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // identity matrix straight out of reset, full-range components pass through
        send_word(make_xform(32'h00010000, 32'h00020000, 32'hfffc8000, 32'h00010000));
        send_word(make_xform(32'h7fffffff, 32'h80000000, 32'hffffffff, 32'h0));
        send_word(make_xform(32'h1, 32'hffffffff, 32'h7fffffff, 32'h80000000));
        // large element times large component saturates high, then low
        send_word(make_write(4'd0, 32'h7fffffff));
        send_word(make_xform(32'h7fffffff, 32'h0, 32'h0, 32'h00010000));
        send_word(make_write(4'd1, 32'h80000000));
        send_word(make_xform(32'h7fffffff, 32'h00010000, 32'h0, 32'h0));
        send_word(make_xform(32'h80000000, 32'h0, 32'h00010000, 32'h0));
        // tiny negative product floors to minus one lsb
        send_word(make_write(4'd15, 32'hffff8000));
        send_word(make_xform(32'h0, 32'h0, 32'h0, 32'h1));
        send_word(make_write(4'd4, 32'h00018000));
        send_word(make_write(4'd14, 32'h0));
        send_word(make_write(4'd10, 32'h80000000));
        send_word(make_xform(32'h00010000, 32'hfffd0000, 32'h3, 32'h00010000));
        send_word(make_xform(32'h00008000, 32'hffff0001, 32'hffffffff, 32'h7fffffff));

        // truncation toward zero on both signs and at the saturation limits
        settle();
        set_round(1'b1);
        send_word(make_write(4'd0, 32'h00010000));
        send_word(make_write(4'd1, 32'h0));
        send_word(make_xform(32'hfffe8000, 32'h00018000, 32'h00014000, 32'hffffc000));
        send_word(make_xform(32'h00018000, 32'hfffe8000, 32'h0, 32'h00010000));
        send_word(make_xform(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h80000000));
        send_word(make_xform(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff));

        for (int phase = 0; phase < 4; phase++) begin
            settle();
            set_round(phase[0]);
            if (phase == 0) begin
                squeeze_req++;
            end
            for (int n = 0; n < PhaseWords; n++) begin
                send_word(random_word());
            end
        end

        settle();
        if (sb.n_errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
